@@ rtl/hrb_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrb_pkg
// Shared types, widths and constants of the radial brush heightmap editor.
// ----------------------------------------------------------------------------
package hrb_pkg;

  localparam int unsigned MAX_RES_DEF = 128;

  localparam int unsigned CHUNK_W = 21;
  localparam int unsigned GRES_W  = 8;
  localparam int unsigned ZS_W    = 16;
  localparam int unsigned CFG_DW  = 21;
  localparam int unsigned CFG_IW  = 2;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned XY_W   = 32;
  localparam int unsigned RAD_W  = 31;
  localparam int unsigned CELL_W = 7;
  localparam int unsigned HGT_W  = 24;

  localparam int unsigned S_TDATA_W = 168;
  localparam int unsigned M_TDATA_W = 32;

  localparam int unsigned DVS_W  = 31;
  localparam int unsigned SQ_W   = 64;
  localparam int unsigned SQ_RW  = 32;
  localparam logic [SQ_W-1:0] SQ_BIT0 = 64'h4000_0000_0000_0000;

  localparam logic [CHUNK_W-1:0] CHUNK_RST = 21'd10000;
  localparam logic [GRES_W-1:0]  GRES_RST  = 8'd128;
  localparam logic [ZS_W-1:0]    ZS_RST    = 16'd256;

  localparam logic [CFG_IW-1:0] REG_CHUNK  = 2'd0;
  localparam logic [CFG_IW-1:0] REG_GRES   = 2'd1;
  localparam logic [CFG_IW-1:0] REG_ZSCALE = 2'd2;

  localparam logic [HGT_W-1:0] HGT_POS_SAT = 24'h7F_FFFF;
  localparam logic [HGT_W-1:0] HGT_NEG_SAT = 24'h80_0000;

  typedef enum logic [OP_W-1:0] {
    OP_STAMP = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_NOP   = 2'd3
  } hrb_op_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CADDR, ST_CRD, ST_CRW, ST_CWR,
    ST_CHK, ST_SKIP, ST_NRMW,
    ST_BBM, ST_BBG, ST_BBW, ST_LOOP,
    ST_PYM, ST_PYG, ST_PYW, ST_PYSQ,
    ST_PXM, ST_PXG, ST_PXW, ST_D2, ST_CMP, ST_SQW,
    ST_AG, ST_AW, ST_ALPHA, ST_DM, ST_UPD,
    ST_NCELL, ST_NROW, ST_FIN
  } hrb_state_e;

endpackage

@@ rtl/hrb_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hrb_div #(
  parameter int unsigned DVD_W = 47,
  parameter int unsigned DVS_W = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [DVD_W-1:0] quotient_o,
  output logic [DVS_W-1:0] remainder_o,
  output logic             busy_o,
  output logic             done_o
);
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q;
  logic [DVS_W-1:0] dvs_q, rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   sh, diff;
  logic             ge;

  assign sh   = {rem_q, dvd_q[DVD_W-1]};
  assign ge   = sh >= {1'b0, dvs_q};
  assign diff = sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
      dvd_q <= {dvd_q[DVD_W-2:0], ge};
    end
  end

  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;
  assign busy_o      = busy_q;
  assign done_o      = done_q;

endmodule

@@ rtl/hrb_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hrb_sqrt
// Integer square root, floor, one result bit per cycle.
// ----------------------------------------------------------------------------
module hrb_sqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hrb_pkg::SQ_W-1:0]  value_i,
  output logic [hrb_pkg::SQ_RW-1:0] root_o,
  output logic                      done_o
);
  import hrb_pkg::*;

  logic [SQ_W-1:0] v_q, res_q, bit_q, t;
  logic            busy_q, done_q, ge;

  assign t  = res_q + bit_q;
  assign ge = v_q >= t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && (bit_q == SQ_W'(1))) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= value_i;
      res_q <= '0;
      bit_q <= SQ_BIT0;
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - t;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign root_o = res_q[SQ_RW-1:0];
  assign done_o = done_q;

endmodule

@@ rtl/heightmap_radial_brush.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heightmap_radial_brush
// Square Q7.16 height grid with cell read/write and a radial brush stamp.
// ----------------------------------------------------------------------------
// One item is in flight at a time. Reads, writes, no-ops, holes and
// zero-radius stamps take no divider pass, nor does a stamp skipped for tiny
// strength. A stamp's setup is strength scaling and four box edges, each a
// pass of the serial divider, then one more pass per box row. A cell costs
// one divider pass when one axis already puts it outside the disk, one pass
// and a squared-distance compare when the full distance test does, and the
// divider twice and the square root once when it is updated. The serial
// divider and the bit-pair square root set the run time. A finished result
// waits in the output register while the next beat is accepted.
// ----------------------------------------------------------------------------
module heightmap_radial_brush #(
  parameter int unsigned MAX_RES = hrb_pkg::MAX_RES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // cfg write port
  input  logic                          cfg_we_i,
  input  logic [hrb_pkg::CFG_IW-1:0]    cfg_idx_i,
  input  logic [hrb_pkg::CFG_DW-1:0]    cfg_data_i,
  // input beats
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // brush_x, brush_y, brush_radius, brush_strength, hole_flag,
  // cell_x, cell_y, cell_value, zero pad
  input  logic [hrb_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation
  input  logic [hrb_pkg::OP_W-1:0]      s_axis_tuser,
  // result beats
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // height_value, modified, zero pad
  output logic [hrb_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import hrb_pkg::*;

  localparam int unsigned RES_W  = $clog2(MAX_RES + 1);
  localparam int unsigned CRD_W  = $clog2(MAX_RES);
  localparam int unsigned IW     = (CRD_W > CELL_W) ? CRD_W : CELL_W;
  localparam int unsigned IDX_W  = IW + RES_W + 1;
  localparam int unsigned DEPTH  = MAX_RES * MAX_RES;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned DVD_W  = (RES_W + 33 > 47) ? RES_W + 33 : 47;
  localparam int unsigned BBP_W  = RES_W + 35;
  localparam int unsigned PK_W   = CRD_W + CHUNK_W + 8;

  hrb_state_e state_q, state_d;

  logic [CHUNK_W-1:0] chunk_q, c_eff;
  logic [GRES_W-1:0]  gres_q;
  logic [ZS_W-1:0]    zs_q, z_eff;
  logic [RES_W-1:0]   res_eff, d_eff;
  logic [RES_W+7:0]   gres_x;
  logic [CHUNK_W+7:0] k_val;
  logic [CHUNK_W+6:0] c128;

  hrb_op_e          op_q;
  logic [31:0]      bx_q, by_q, str_q, mag_str;
  logic [30:0]      r_q;
  logic [CELL_W-1:0] cxi_q, cyi_q;
  logic [HGT_W-1:0] cval_q, hv_q, rdata_q, out_hv_q, mem_wdata;
  logic             vld_q, mod_q, out_valid_q, out_mod_q;

  logic [45:0]      skp_q, skp_d;
  logic [61:0]      rr_q, rr_d, ady2_q, ady2_d;
  logic             below;
  logic [39:0]      nmag_q;

  logic [1:0]            bb_q;
  logic [33:0]           bxs, bys, base, nlo, nhi;
  logic signed [33:0]    nsel;
  logic signed [RES_W:0] dsg;
  logic signed [BBP_W-1:0] bbp;
  logic [BBP_W-1:0]      bbp_q, bbabs;
  logic                  bbneg, negv;
  logic [DVD_W:0]        fq;
  logic [CRD_W-1:0]      bbclip;
  logic [CRD_W-1:0]      x0_q, x1_q, y0_q, y1_q, x_q, y_q, coord;
  logic                  x1n_q, y1n_q, empty;

  logic [PK_W-1:0]   pk_q, pk_d;
  logic [IDX_W-1:0]  idx_rw, idx_st;
  logic [ADDR_W-1:0] idx_q;

  logic [33:0] pxy, base2, dd, add;
  logic        far;
  logic [30:0] ady_q, adx_q, dist_q;
  logic [63:0] d2_q, d2_d;
  logic [16:0] a_q, alpha_q;
  logic [33:0] asq;
  logic [56:0] dmp;
  logic [40:0] dm_q;
  logic [42:0] cell43, dl43, hsum;
  logic [HGT_W-1:0] hsat;

  logic             div_start, div_busy, div_done;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs, div_r;
  logic             sq_start, sq_done;
  logic [SQ_RW-1:0] sq_root;

  logic mem_we, out_load, s_acc;

  logic [HGT_W-1:0] grid_mem [DEPTH];

  // ---------------------------------------------------------------- config
  always_comb begin
    c_eff  = (chunk_q == '0) ? CHUNK_W'(1) : chunk_q;
    z_eff  = (zs_q == '0) ? ZS_W'(1) : zs_q;
    gres_x = (RES_W + 8)'(gres_q);
    if (gres_q < GRES_W'(2)) begin
      res_eff = RES_W'(2);
    end else if (gres_x > (RES_W + 8)'(MAX_RES)) begin
      res_eff = RES_W'(MAX_RES);
    end else begin
      res_eff = RES_W'(gres_q);
    end
    d_eff = res_eff - 1'b1;
    k_val = {c_eff, 8'd0};
    c128  = {c_eff, 7'd0};
  end

  // -------------------------------------------------------------- datapath
  always_comb begin
    mag_str = str_q[31] ? (32'd0 - str_q) : str_q;
    skp_d   = mag_str * 14'd10000;
    rr_d    = r_q * r_q;
    below   = skp_q < {22'd0, z_eff, 8'd0};

    bxs  = {{2{bx_q[31]}}, bx_q};
    bys  = {{2{by_q[31]}}, by_q};
    base = bb_q[1] ? bys : bxs;
    nlo  = base - {3'd0, r_q} + {6'd0, c128};
    nhi  = base + {3'd0, r_q} + 34'd1 + {6'd0, c128};
    nsel = bb_q[0] ? nhi : nlo;
    dsg  = {1'b0, d_eff};
    bbp  = nsel * dsg;

    bbneg  = bbp_q[BBP_W-1];
    bbabs  = bbneg ? (~bbp_q + 1'b1) : bbp_q;
    fq     = {1'b0, div_q} + (DVD_W + 1)'(bbneg && (div_r != '0));
    negv   = bbneg && (fq != '0);
    bbclip = (div_q > DVD_W'(d_eff)) ? CRD_W'(d_eff) : CRD_W'(div_q);
    empty  = x1n_q || y1n_q || (x0_q > x1_q) || (y0_q > y1_q);

    coord  = (state_q == ST_PYM) ? y_q : x_q;
    pk_d   = coord * k_val;
    idx_rw = cyi_q * res_eff + cxi_q;
    idx_st = y_q * res_eff + x_q;

    pxy   = {5'd0, div_q[28:0]} - {6'd0, c128};
    base2 = (state_q == ST_PYW) ? bys : bxs;
    dd    = base2 - pxy;
    add   = dd[33] ? (34'd0 - dd) : dd;
    far   = add > {3'd0, r_q};

    ady2_d = ady_q * ady_q;
    d2_d   = adx_q * adx_q + ady2_q;
    asq    = a_q * a_q;
    dmp    = nmag_q * alpha_q;

    cell43 = {{19{rdata_q[HGT_W-1]}}, rdata_q};
    dl43   = str_q[31] ? (43'd0 - {2'd0, dm_q}) : {2'd0, dm_q};
    hsum   = cell43 + dl43;
    if (!hsum[42] && (|hsum[42:23])) begin
      hsat = HGT_POS_SAT;
    end else if (hsum[42] && !(&hsum[42:23])) begin
      hsat = HGT_NEG_SAT;
    end else begin
      hsat = hsum[HGT_W-1:0];
    end
  end

  always_comb begin
    div_dvd = DVD_W'(pk_q);
    div_dvs = DVS_W'(d_eff);
    unique case (state_q)
      ST_SKIP: begin
        div_dvd = DVD_W'({mag_str, 8'd0});
        div_dvs = DVS_W'(z_eff);
      end
      ST_BBG: begin
        div_dvd = DVD_W'(bbabs);
        div_dvs = DVS_W'(k_val);
      end
      ST_AG: begin
        div_dvd = DVD_W'({r_q - dist_q, 16'd0});
        div_dvs = r_q;
      end
      default: begin
        div_dvd = DVD_W'(pk_q);
        div_dvs = DVS_W'(d_eff);
      end
    endcase
  end

  hrb_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_q),
    .remainder_o(div_r),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  hrb_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sq_start),
    .value_i(d2_q),
    .root_o (sq_root),
    .done_o (sq_done)
  );

  // ------------------------------------------------------------ next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            OP_STAMP: state_d = (s_axis_tdata[127] || (s_axis_tdata[94:64] == '0)) ?
                                ST_FIN : ST_CHK;
            OP_READ, OP_WRITE: state_d = ST_CADDR;
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_CADDR: state_d = (op_q == OP_READ) ? ST_CRD : ST_CWR;
      ST_CRD:   state_d = ST_CRW;
      ST_CRW:   state_d = ST_FIN;
      ST_CWR:   state_d = ST_FIN;
      ST_CHK:   state_d = ST_SKIP;
      ST_SKIP:  state_d = below ? ST_FIN : ST_NRMW;
      ST_NRMW:  if (div_done) state_d = ST_BBM;
      ST_BBM:   state_d = ST_BBG;
      ST_BBG:   state_d = ST_BBW;
      ST_BBW:   if (div_done) state_d = (bb_q == 2'd3) ? ST_LOOP : ST_BBM;
      ST_LOOP:  state_d = empty ? ST_FIN : ST_PYM;
      ST_PYM:   state_d = ST_PYG;
      ST_PYG:   state_d = ST_PYW;
      ST_PYW:   if (div_done) state_d = far ? ST_NROW : ST_PYSQ;
      ST_PYSQ:  state_d = ST_PXM;
      ST_PXM:   state_d = ST_PXG;
      ST_PXG:   state_d = ST_PXW;
      ST_PXW:   if (div_done) state_d = far ? ST_NCELL : ST_D2;
      ST_D2:    state_d = ST_CMP;
      ST_CMP:   state_d = (d2_q > {2'd0, rr_q}) ? ST_NCELL : ST_SQW;
      ST_SQW:   if (sq_done) state_d = ST_AG;
      ST_AG:    state_d = ST_AW;
      ST_AW:    if (div_done) state_d = ST_ALPHA;
      ST_ALPHA: state_d = ST_DM;
      ST_DM:    state_d = ST_UPD;
      ST_UPD:   state_d = ST_NCELL;
      ST_NCELL: state_d = (x_q == x1_q) ? ST_NROW : ST_PXM;
      ST_NROW:  state_d = (y_q == y1_q) ? ST_FIN : ST_PYM;
      ST_FIN:   if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------- outputs
  always_comb begin
    s_axis_tready = 1'b0;
    div_start     = 1'b0;
    sq_start      = 1'b0;
    mem_we        = 1'b0;
    mem_wdata     = hsat;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_SKIP: div_start = !below;
      ST_BBG, ST_PYG, ST_PXG, ST_AG: div_start = 1'b1;
      ST_CMP:  sq_start = !(d2_q > {2'd0, rr_q});
      ST_CWR: begin
        mem_we    = vld_q;
        mem_wdata = cval_q;
      end
      ST_UPD:  mem_we = 1'b1;
      ST_FIN:  out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // ------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      chunk_q     <= CHUNK_RST;
      gres_q      <= GRES_RST;
      zs_q        <= ZS_RST;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_CHUNK:  chunk_q <= cfg_data_i;
          REG_GRES:   gres_q  <= cfg_data_i[GRES_W-1:0];
          REG_ZSCALE: zs_q    <= cfg_data_i[ZS_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hv_q  <= hv_q;
      out_mod_q <= mod_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (s_acc) begin
          op_q  <= hrb_op_e'(s_axis_tuser);
          bx_q  <= s_axis_tdata[31:0];
          by_q  <= s_axis_tdata[63:32];
          r_q   <= s_axis_tdata[94:64];
          str_q <= s_axis_tdata[126:95];
          cxi_q <= s_axis_tdata[134:128];
          cyi_q <= s_axis_tdata[141:135];
          cval_q <= s_axis_tdata[165:142];
          mod_q <= 1'b0;
          hv_q  <= '0;
          bb_q  <= '0;
        end
      end
      ST_CADDR: begin
        vld_q <= ((RES_W + CELL_W)'(cxi_q) < (RES_W + CELL_W)'(res_eff)) &&
                 ((RES_W + CELL_W)'(cyi_q) < (RES_W + CELL_W)'(res_eff));
        idx_q <= idx_rw[ADDR_W-1:0];
      end
      ST_CRW: hv_q <= vld_q ? rdata_q : '0;
      ST_CHK: begin
        skp_q <= skp_d;
        rr_q  <= rr_d;
      end
      ST_NRMW: if (div_done) nmag_q <= div_q[39:0];
      ST_BBM:  bbp_q <= bbp;
      ST_BBW: begin
        if (div_done) begin
          bb_q <= bb_q + 1'b1;
          case (bb_q)
            2'd0: x0_q <= negv ? '0 : bbclip;
            2'd1: begin
              x1_q  <= bbclip;
              x1n_q <= negv;
            end
            2'd2: y0_q <= negv ? '0 : bbclip;
            default: begin
              y1_q  <= bbclip;
              y1n_q <= negv;
            end
          endcase
        end
      end
      ST_LOOP: y_q <= y0_q;
      ST_PYM: begin
        pk_q <= pk_d;
        x_q  <= x0_q;
      end
      ST_PYW:  if (div_done) ady_q <= add[30:0];
      ST_PYSQ: ady2_q <= ady2_d;
      ST_PXM: begin
        pk_q  <= pk_d;
        idx_q <= idx_st[ADDR_W-1:0];
      end
      ST_PXW:  if (div_done) adx_q <= add[30:0];
      ST_D2:   d2_q <= d2_d;
      ST_SQW:  if (sq_done) dist_q <= sq_root[30:0];
      ST_AW:   if (div_done) a_q <= div_q[16:0];
      ST_ALPHA: alpha_q <= asq[32:16];
      ST_DM:   dm_q <= dmp[56:16];
      ST_UPD:  mod_q <= 1'b1;
      ST_NCELL: if (x_q != x1_q) x_q <= x_q + 1'b1;
      ST_NROW:  if (y_q != y1_q) y_q <= y_q + 1'b1;
      default: ;
    endcase
  end

  // height grid, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      grid_mem[idx_q] <= mem_wdata;
    end
    rdata_q <= grid_mem[idx_q];
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_mod_q, out_hv_q};

  // ------------------------------------------------------------ assertions
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_UPD || state_q == ST_CWR))
    else $error("grid write outside a write state");

  a_cell_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (x_q <= CRD_W'(d_eff) && y_q <= CRD_W'(d_eff)))
    else $error("stamp cell outside grid");

  a_disk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPD) |-> (d2_q <= {2'd0, rr_q}))
    else $error("stamp update outside brush disk");

  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q != ST_IDLE))
    else $error("accepted beat dropped");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radial brush heightmap editor. A scoreboard class
// keeps its own height grid and register copy, predicts the height and the
// modified flag of every accepted beat, and compares each result beat in
// order. Directed beats cover the field extremes and special cases, then
// random phases under several register settings, with bursty input and
// stalled output.
// ----------------------------------------------------------------------------
module tb;
  import hrb_pkg::*;

  localparam int unsigned GRID_N = MAX_RES_DEF * MAX_RES_DEF;
  localparam int unsigned CYCLE_LIMIT = 40_000_000;

  typedef struct {
    hrb_op_e            op;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [30:0]        rad;
    logic signed [31:0] str;
    logic               hole;
    logic [6:0]         cx;
    logic [6:0]         cy;
    logic signed [23:0] val;
  } brush_item_t;

  class brush_scoreboard;
    bit [CHUNK_W-1:0]   chunk;
    bit [GRES_W-1:0]    gres;
    bit [ZS_W-1:0]      zs;
    logic signed [23:0] grid[GRID_N];
    bit                 written[GRID_N];
    int                 missing[$];
    bit [23:0]          exp_height[$];
    bit                 exp_mod[$];
    int                 errors;

    function new();
      chunk = CHUNK_RST;
      gres  = GRES_RST;
      zs    = ZS_RST;
      errors = 0;
      foreach (grid[i]) begin
        grid[i] = '0;
        written[i] = 1'b0;
      end
    endfunction

    function longint res();
      if (gres < 2) return 2;
      if (gres > MAX_RES_DEF) return MAX_RES_DEF;
      return gres;
    endfunction

    function longint fdiv(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d) != 0 && n < 0) q--;
      return q;
    endfunction

    function longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned acc, b;
      acc = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= acc + b) begin
          v -= acc + b;
          acc = (acc >> 1) + b;
        end else begin
          acc >>= 1;
        end
        b >>= 2;
      end
      return acc;
    endfunction

    // apply=0 only lists never-written cells that the stamp would reach
    function bit brush_reach(brush_item_t it, bit apply);
      longint c, z, n, d, k, bx, by, r, s, mag, norm, x0, x1, y0, y1, px, py;
      longint dst, a, alpha, dm, delta, h, idx;
      longint unsigned r2, adx, ady, d2;
      bit hit;
      hit = 0;
      if (it.hole || it.rad == 0) return 0;
      c = chunk ? chunk : 1;
      z = zs ? zs : 1;
      n = res();
      d = n - 1;
      k = c * 256;
      bx = it.bx; by = it.by; r = it.rad; s = it.str;
      mag = s < 0 ? -s : s;
      r2 = r * r;
      if (mag * 10000 < 256 * z) return 0;
      norm = (s * 256) / z;
      x0 = clip(clip(fdiv((bx - r + c * 128) * d, k), -1, n), 0, d);
      x1 = clip(clip(fdiv((bx + r + 1 + c * 128) * d, k), -1, n), -1, d);
      y0 = clip(clip(fdiv((by - r + c * 128) * d, k), -1, n), 0, d);
      y1 = clip(clip(fdiv((by + r + 1 + c * 128) * d, k), -1, n), -1, d);
      for (longint y = y0; y <= y1; y++) begin
        py = (y * k) / d - c * 128;
        ady = (by - py) < 0 ? py - by : by - py;
        for (longint x = x0; x <= x1; x++) begin
          px = (x * k) / d - c * 128;
          adx = (bx - px) < 0 ? px - bx : bx - px;
          d2 = adx * adx + ady * ady;
          if (d2 > r2) continue;
          hit = 1;
          idx = y * n + x;
          if (!apply) begin
            if (!written[idx]) missing.push_back(int'(idx));
            continue;
          end
          dst = longint'(root(d2));
          a = ((r - dst) * 65536) / r;
          alpha = (a * a) / 65536;
          dm = ((norm < 0 ? -norm : norm) * alpha) / 65536;
          delta = norm < 0 ? -dm : dm;
          h = clip(longint'(grid[idx]) + delta, -8388608, 8388607);
          grid[idx] = h[23:0];
        end
      end
      return hit;
    endfunction

    function void note_input(brush_item_t it);
      bit [23:0] hv;
      bit m;
      longint n;
      hv = '0;
      m = 0;
      n = res();
      case (it.op)
        OP_STAMP: m = brush_reach(it, 1);
        OP_READ:  if (it.cx < n && it.cy < n) hv = grid[it.cy * n + it.cx];
        OP_WRITE: if (it.cx < n && it.cy < n) begin
          grid[it.cy * n + it.cx] = it.val;
          written[it.cy * n + it.cx] = 1'b1;
        end
        default: ;
      endcase
      exp_height.push_back(hv);
      exp_mod.push_back(m);
    endfunction

    function void check_result(bit [23:0] hv, bit m);
      bit [23:0] eh;
      bit em;
      if (exp_height.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result beat with nothing expected");
        return;
      end
      eh = exp_height.pop_front();
      em = exp_mod.pop_front();
      if (eh !== hv || em !== m) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: height exp %h got %h, modified exp %0b got %0b", eh, hv, em, m);
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IW-1:0]    cfg_idx_i = '0;
  logic [CFG_DW-1:0]    cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // bx, by, radius, strength, hole, cx, cy, value
  logic [OP_W-1:0]      s_axis_tuser = '0;  // operation
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // height_value, modified

  brush_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;
  longint cycles = 0;

  heightmap_radial_brush dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL heightmap_radial_brush");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[23:0], m_axis_tdata[24]);
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_cnt = $urandom_range(20, 300);
    end
    stall_cnt--;
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 7) == 0);
      default: m_axis_tready <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic brush_item_t mk(hrb_op_e op, logic [31:0] bx, logic [31:0] by,
                                     logic [30:0] rad, logic [31:0] str, logic hole,
                                     logic [6:0] cx, logic [6:0] cy, logic [23:0] val);
    brush_item_t it;
    it.op = op; it.bx = bx; it.by = by; it.rad = rad; it.str = str;
    it.hole = hole; it.cx = cx; it.cy = cy; it.val = val;
    return it;
  endfunction

  task automatic send(brush_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      if ($urandom_range(0, 3) != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {2'b0, it.val, it.cy, it.cx, it.hole, it.str, it.rad, it.by, it.bx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  task automatic write_cell(int x, int y, logic [23:0] v);
    send(mk(OP_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom, x, y, v));
  endtask

  // never-written cells get loaded before a beat would touch them
  task automatic fill_then_send(brush_item_t it);
    int n, idx;
    n = int'(sb.res());
    if (it.op == OP_STAMP) begin
      sb.missing.delete();
      void'(sb.brush_reach(it, 0));
      foreach (sb.missing[i]) write_cell(sb.missing[i] % n, sb.missing[i] / n, $urandom);
    end else if (it.op == OP_READ && it.cx < n && it.cy < n) begin
      idx = it.cy * n + it.cx;
      if (!sb.written[idx]) write_cell(it.cx, it.cy, $urandom);
    end
    send(it);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.exp_height.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_CHUNK:  sb.chunk = v;
      REG_GRES:   sb.gres = v[GRES_W-1:0];
      REG_ZSCALE: sb.zs = v[ZS_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int c, int g, int z);
    wait_idle();
    cfg_write(REG_CHUNK, c);
    cfg_write(REG_GRES, g);
    cfg_write(REG_ZSCALE, z);
  endtask

  function automatic brush_item_t rand_stamp();
    brush_item_t it;
    longint c, n, k, s, gx, gy;
    c = sb.chunk ? sb.chunk : 1;
    n = sb.res();
    k = c * 256;
    s = k / (n - 1);
    gx = longint'($urandom_range(0, n + 1)) - 1;
    gy = longint'($urandom_range(0, n + 1)) - 1;
    it = mk(OP_STAMP, 0, 0, 0, 0, 0, $urandom, $urandom, $urandom);
    it.bx = (gx * k) / (n - 1) - c * 128 + longint'($urandom_range(0, 2 * s)) - s;
    it.by = (gy * k) / (n - 1) - c * 128 + longint'($urandom_range(0, 2 * s)) - s;
    it.rad = 1 + $urandom_range(0, (s * 3) / 2);
    if (n <= 4 && $urandom_range(0, 15) == 0) it.rad = $urandom;
    it.str = $signed($urandom) >>> $urandom_range(0, 24);
    it.hole = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 19) == 0) it.rad = 0;
    return it;
  endfunction

  task automatic random_phase(int count);
    brush_item_t it;
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (i == count / 2) wait_idle();
      if (sel < 30) begin
        it = rand_stamp();
      end else if (sel < 60) begin
        it = mk(OP_WRITE, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, sb.res() - 1), $urandom_range(0, sb.res() - 1), $urandom);
        if ($urandom_range(0, 9) == 0) it.cx = $urandom;
      end else if (sel < 90) begin
        it = mk(OP_READ, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom_range(0, sb.res() - 1), $urandom_range(0, sb.res() - 1), $urandom);
        if ($urandom_range(0, 9) == 0) it.cy = $urandom;
      end else begin
        it = mk(hrb_op_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                $urandom, $urandom, $urandom, $urandom);
        if (it.op == OP_STAMP && sb.res() > 4) it.hole = 1'b1;
      end
      fill_then_send(it);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // directed: extremes, out-of-grid cells, unused op
    write_cell(0, 0, 24'h7F_FFFF);
    write_cell(127, 127, 24'h80_0000);
    fill_then_send(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0));
    fill_then_send(mk(OP_READ, 0, 0, 0, 0, 0, 127, 127, 0));
    send(mk(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, 1, '1, '1, '1));
    set_config(10000, 2, 1);
    write_cell(0, 0, 24'h7F_FFFF);
    write_cell(1, 0, 24'h80_0000);
    write_cell(0, 1, 0);
    write_cell(1, 1, 24'h00_0001);
    send(mk(OP_READ, 0, 0, 0, 0, 0, 2, 0, 0));
    send(mk(OP_WRITE, 0, 0, 0, 0, 0, 0, 2, 24'h12_3456));
    send(mk(OP_STAMP, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0));
    send(mk(OP_STAMP, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0));
    send(mk(OP_STAMP, 0, 0, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0));
    send(mk(OP_STAMP, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0, 0));
    send(mk(OP_STAMP, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 0, 0));
    send(mk(OP_STAMP, -32'sd1280000, -32'sd1280000, 1, 32'h0000_0100, 0, 0, 0, 0));
    send(mk(OP_STAMP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16, 32'h0000_1000, 0, 0, 0, 0));
    for (int i = 0; i < 4; i++) send(mk(OP_READ, 0, 0, 0, 0, 0, i % 2, i / 2, 0));
    set_config(10000, 2, 65535);
    send(mk(OP_STAMP, 0, 0, 31'h7FFF_FFFF, 32'h0000_0600, 0, 0, 0, 0));
    send(mk(OP_STAMP, 0, 0, 31'h7FFF_FFFF, -32'sd1000, 0, 0, 0, 0));

    set_config(10000, 128, 256);
    random_phase(150);
    set_config(1, 128, 1);
    random_phase(150);
    set_config(1048576, 16, 65535);
    random_phase(150);
    set_config(0, 0, 0);
    random_phase(140);
    set_config(300, 255, 100);
    random_phase(140);
    set_config(2097151, 5, 65535);
    random_phase(140);
    set_config(5000, 1, 40);
    random_phase(140);
    set_config(777, 7, 3000);
    random_phase(140);
    set_config($urandom_range(1, 1048576), $urandom_range(2, 40), $urandom_range(1, 65535));
    random_phase(150);

    wait_idle();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.exp_height.size() == 0) begin
      $display("PASS heightmap_radial_brush");
    end else begin
      $display("FAIL heightmap_radial_brush");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/hrb_pkg.sv
rtl/hrb_div.sv
rtl/hrb_sqrt.sv
rtl/heightmap_radial_brush.sv
test/tb.sv
